// ===== hdl/route_great_circle_length_assert.svh =====
// ----------------------------------------------------------------------------
// Route great-circle length assertion macros
// Shared property templates clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ROUTE_GREAT_CIRCLE_LENGTH_ASSERT_SVH
`define ROUTE_GREAT_CIRCLE_LENGTH_ASSERT_SVH

// same-cycle implication
`define RGCL_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rgcl assertion failed");

// next-cycle implication
`define RGCL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rgcl assertion failed");

`endif

// ===== hdl/rgcl_pkg.sv =====
// ----------------------------------------------------------------------------
// Route great-circle length package
// Fixed-point constants, the CORDIC arctangent table and shared types.
// ----------------------------------------------------------------------------
package rgcl_pkg;

	localparam int CORDIC_ITERATIONS = 32;
	localparam int IW = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
	localparam int DW = 36;
	localparam int MW = 36;
	localparam int PW = 2 * MW;

	typedef logic signed [DW-1:0] dat_t;
	typedef logic signed [MW-1:0] mop_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [29:0]   ang_t;
	typedef dat_t atan_tab_t [CORDIC_ITERATIONS];

	typedef struct packed {
		logic start;
		logic vector;
	} cord_ctl_t;

	localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
	localparam logic [63:0] PI_Q30_W = (PI_Q60 + 64'd536870912) >> 30;
	localparam logic [63:0] F_RAD_W  = PI_Q60 / 64'd180000000;
	localparam dat_t PI_Q30  = dat_t'(PI_Q30_W[DW-1:0]);
	localparam dat_t GAIN    = 36'sh026DD3B6A;
	localparam dat_t ONE_Q30 = 36'sd1073741824;

	localparam ang_t UDEG_FULL    = 30'sd360000000;
	localparam ang_t UDEG_HALF    = 30'sd180000000;
	localparam ang_t UDEG_QUARTER = 30'sd90000000;

	localparam logic [47:0] LEN_MAX = 48'hFFFF_FFFF_FFFF;

	function automatic logic [63:0] divu64(logic [63:0] num, logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic atan_tab_t build_atan();
		atan_tab_t   tab;
		logic [63:0] sum;
		logic [63:0] term;
		logic [63:0] rnd;
		int          e;
		rnd = (PI_Q60 + 64'h8000_0000) >> 32;
		tab[0] = dat_t'(rnd[DW-1:0]);
		for (int i = 1; i < CORDIC_ITERATIONS; i++) begin
			sum = '0;
			for (int k = 0; k < 32; k++) begin
				e = 62 - i * (2 * k + 1);
				if (e >= 0) begin
					term = divu64(64'd1 << e, 64'(2 * k + 1));
					if (k % 2 == 1) sum = sum - term;
					else sum = sum + term;
				end
			end
			rnd = (sum + 64'h8000_0000) >> 32;
			tab[i] = dat_t'(rnd[DW-1:0]);
		end
		return tab;
	endfunction

	localparam atan_tab_t ATAN_TAB = build_atan();

endpackage

// ===== hdl/rgcl_if.sv =====
// ----------------------------------------------------------------------------
// Route great-circle length channels
// Valid/ready channels for stops, results and the radius register.
// ----------------------------------------------------------------------------
interface rgcl_stop_if;
	logic               valid;
	logic               ready;
	logic signed [27:0] latitude_udeg;
	logic signed [28:0] longitude_udeg;
	logic               new_route;
	modport source (output valid, latitude_udeg, longitude_udeg, new_route, input ready);
	modport sink (input valid, latitude_udeg, longitude_udeg, new_route, output ready);
endinterface

interface rgcl_result_if;
	logic        valid;
	logic        ready;
	logic [47:0] route_length_mm;
	logic [15:0] stop_total;
	logic        length_saturated;
	modport source (output valid, route_length_mm, stop_total, length_saturated, input ready);
	modport sink (input valid, route_length_mm, stop_total, length_saturated, output ready);
endinterface

interface rgcl_cfg_if;
	logic        valid;
	logic        ready;
	logic [23:0] earth_radius_m;
	modport source (output valid, earth_radius_m, input ready);
	modport sink (input valid, earth_radius_m, output ready);
endinterface

// ===== hdl/route_great_circle_length.sv =====
// A first stop, a repeated stop or a new_route stop skips the leg and goes
// straight to S_DONE. Other stops go through four passes of the shared CORDIC unit
// and the bit-serial square root before the leg length is added.
// Throughput: one stop at a time; stop.ready is high only while the sequencer idles.
// Reset: arst_n clears route state and loads the radius with 6371000 m.
// ----------------------------------------------------------------------------
// Route great-circle length
// Accumulates spherical law-of-cosines leg lengths over a stream of stops.
// ----------------------------------------------------------------------------
module route_great_circle_length (
	input logic           clk,
	input logic           arst_n,
	rgcl_stop_if.sink     stop,
	rgcl_result_if.source result,
	rgcl_cfg_if.sink      cfg
);
	import rgcl_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_RED, S_RADMUL, S_RADRD, S_ROT,
		S_DOT1, S_DOT2, S_DOT3, S_DOT4, S_SQMUL, S_SQST, S_SQW, S_VEC,
		S_RMUL, S_MM1, S_MM2, S_MM3, S_DONE
	} state_t;

	typedef struct packed {
		logic [26:0] mag;
		logic        neg;
		logic        negc;
	} red_t;

	function automatic red_t reduce(ang_t a);
		ang_t v;
		ang_t m;
		red_t r;
		v = a;
		if (v >= UDEG_FULL) v = v - UDEG_FULL;
		else if (v <= -UDEG_FULL) v = v + UDEG_FULL;
		if (v >= UDEG_HALF) v = v - UDEG_FULL;
		else if (v < -UDEG_HALF) v = v + UDEG_FULL;
		r.negc = 1'b0;
		if (v > UDEG_QUARTER) begin
			v = UDEG_HALF - v;
			r.negc = 1'b1;
		end else if (v < -UDEG_QUARTER) begin
			v = -UDEG_HALF - v;
			r.negc = 1'b1;
		end
		r.neg = v[29];
		m = v[29] ? -v : v;
		r.mag = m[26:0];
		return r;
	endfunction

	state_t             state_q;
	logic [1:0]         j_q;
	logic [23:0]        radius_q;
	logic signed [27:0] prev_lat_q;
	logic signed [28:0] prev_lon_q;
	logic signed [27:0] new_lat_q;
	logic signed [28:0] new_lon_q;
	logic               have_q;
	logic [47:0]        acc_q;
	logic [15:0]        cnt_q;
	logic [26:0]        mag_q;
	logic               neg_q;
	logic               negc_q;
	dat_t               s_q [3];
	dat_t               c_q [3];
	dat_t               p1_q;
	dat_t               dot_q;
	logic [30:0]        vmag_q;
	logic [31:0]        th_q;
	logic [29:0]        lo_q;
	logic [35:0]        hk_q;
	logic               res_valid_q;
	logic [47:0]        res_len_q;
	logic [15:0]        res_cnt_q;
	logic               res_sat_q;

	mop_t        mul_a;
	mop_t        mul_b;
	prod_t       prod;
	prod_t       prod_sh;
	dat_t        prod_shd;
	prod_t       prod_rnd;
	dat_t        rad;
	ang_t        angle;
	red_t        red;
	cord_ctl_t   cord_ctl;
	dat_t        cx0;
	dat_t        cy0;
	dat_t        cz0;
	dat_t        cx;
	dat_t        cy;
	dat_t        cz;
	logic        cord_done;
	logic        sq_start;
	logic [60:0] sq_n;
	logic [30:0] sq_r;
	logic        sq_done;
	dat_t        dot_v;
	dat_t        th_v;
	logic [36:0] mm;
	logic [48:0] sum;
	logic        accept;
	logic        nr;
	logic        leg;
	logic [47:0] acc_eff;
	logic [15:0] cnt_eff;

	assign stop.ready = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;
	assign accept     = stop.valid && stop.ready;

	assign result.valid            = res_valid_q;
	assign result.route_length_mm  = res_len_q;
	assign result.stop_total       = res_cnt_q;
	assign result.length_saturated = res_sat_q;

	assign prod_sh  = prod >>> 30;
	assign prod_shd = dat_t'(prod_sh[DW-1:0]);
	assign prod_rnd = prod + 72'sd536870912;
	assign rad      = neg_q ? -dat_t'({4'd0, prod_rnd[61:30]})
	                        : dat_t'({4'd0, prod_rnd[61:30]});

	always_comb begin
		case (j_q)
			2'd0:    angle = ang_t'({{2{prev_lat_q[27]}}, prev_lat_q});
			2'd1:    angle = ang_t'({{2{new_lat_q[27]}}, new_lat_q});
			default: angle = ang_t'({prev_lon_q[28], prev_lon_q})
			               - ang_t'({new_lon_q[28], new_lon_q});
		endcase
	end

	assign red = reduce(angle);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_RADMUL: begin
				mul_a = mop_t'({9'd0, mag_q});
				mul_b = mop_t'({1'b0, F_RAD_W[34:0]});
			end
			S_DOT1: begin
				mul_a = s_q[0];
				mul_b = s_q[1];
			end
			S_DOT2: begin
				mul_a = c_q[0];
				mul_b = c_q[1];
			end
			S_DOT3: begin
				mul_a = prod_shd;
				mul_b = c_q[2];
			end
			S_SQMUL: begin
				mul_a = mop_t'({5'd0, vmag_q});
				mul_b = mop_t'({5'd0, vmag_q});
			end
			S_RMUL: begin
				mul_a = mop_t'({12'd0, radius_q});
				mul_b = mop_t'({4'd0, th_q});
			end
			S_MM1: begin
				mul_a = mop_t'({10'd0, prod[55:30]});
				mul_b = 36'sd1000;
			end
			S_MM2: begin
				mul_a = mop_t'({6'd0, lo_q});
				mul_b = 36'sd1000;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	rgcl_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	assign sq_start = (state_q == S_SQST);
	assign sq_n     = (61'd1 << 60) - prod[60:0];

	rgcl_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.n      (sq_n),
		.r      (sq_r),
		.done   (sq_done)
	);

	assign cord_ctl.start  = (state_q == S_RADRD) || (state_q == S_SQW && sq_done);
	assign cord_ctl.vector = (state_q == S_SQW);
	assign cx0 = cord_ctl.vector ? dat_t'({5'd0, vmag_q}) : GAIN;
	assign cy0 = cord_ctl.vector ? dat_t'({5'd0, sq_r}) : '0;
	assign cz0 = cord_ctl.vector ? '0 : rad;

	rgcl_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cord_ctl),
		.x0     (cx0),
		.y0     (cy0),
		.z0     (cz0),
		.x      (cx),
		.y      (cy),
		.z      (cz),
		.done   (cord_done)
	);

	always_comb begin
		dot_v = p1_q + prod_shd;
		if (dot_v > ONE_Q30) dot_v = ONE_Q30;
		if (dot_v < -ONE_Q30) dot_v = -ONE_Q30;
		th_v = dot_q[DW-1] ? (PI_Q30 - cz) : cz;
		if (th_v < 0) th_v = '0;
		if (th_v > PI_Q30) th_v = PI_Q30;
	end

	assign mm  = 37'(hk_q) + 37'(prod_rnd[39:30]);
	assign sum = {1'b0, acc_q} + 49'(mm);

	assign nr      = stop.new_route;
	assign acc_eff = nr ? '0 : acc_q;
	assign cnt_eff = nr ? '0 : cnt_q;
	assign leg     = have_q && !nr && !(stop.latitude_udeg == prev_lat_q
	                 && stop.longitude_udeg == prev_lon_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			j_q         <= '0;
			radius_q    <= 24'd6371000;
			prev_lat_q  <= '0;
			prev_lon_q  <= '0;
			new_lat_q   <= '0;
			new_lon_q   <= '0;
			have_q      <= 1'b0;
			acc_q       <= '0;
			cnt_q       <= '0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			negc_q      <= 1'b0;
			s_q         <= '{default: '0};
			c_q         <= '{default: '0};
			p1_q        <= '0;
			dot_q       <= '0;
			vmag_q      <= '0;
			th_q        <= '0;
			lo_q        <= '0;
			hk_q        <= '0;
			res_valid_q <= 1'b0;
			res_len_q   <= '0;
			res_cnt_q   <= '0;
			res_sat_q   <= 1'b0;
		end else begin
			if (cfg.valid) radius_q <= cfg.earth_radius_m;
			if (res_valid_q && result.ready && state_q != S_DONE) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						new_lat_q <= stop.latitude_udeg;
						new_lon_q <= stop.longitude_udeg;
						have_q    <= 1'b1;
						acc_q     <= acc_eff;
						cnt_q     <= (cnt_eff == 16'hFFFF) ? cnt_eff : cnt_eff + 16'd1;
						j_q       <= '0;
						state_q   <= leg ? S_RED : S_DONE;
					end
				end
				S_RED: begin
					mag_q   <= red.mag;
					neg_q   <= red.neg;
					negc_q  <= red.negc;
					state_q <= S_RADMUL;
				end
				S_RADMUL: state_q <= S_RADRD;
				S_RADRD:  state_q <= S_ROT;
				S_ROT: begin
					if (cord_done) begin
						s_q[j_q] <= cy;
						c_q[j_q] <= negc_q ? -cx : cx;
						if (j_q == 2'd2) begin
							state_q <= S_DOT1;
						end else begin
							j_q     <= j_q + 2'd1;
							state_q <= S_RED;
						end
					end
				end
				S_DOT1: state_q <= S_DOT2;
				S_DOT2: begin
					p1_q    <= prod_shd;
					state_q <= S_DOT3;
				end
				S_DOT3: state_q <= S_DOT4;
				S_DOT4: begin
					dot_q   <= dot_v;
					vmag_q  <= dot_v[DW-1] ? 31'(-dot_v) : 31'(dot_v);
					state_q <= S_SQMUL;
				end
				S_SQMUL: state_q <= S_SQST;
				S_SQST:  state_q <= S_SQW;
				S_SQW: begin
					if (sq_done) state_q <= S_VEC;
				end
				S_VEC: begin
					if (cord_done) begin
						th_q    <= th_v[31:0];
						state_q <= S_RMUL;
					end
				end
				S_RMUL: state_q <= S_MM1;
				S_MM1: begin
					lo_q    <= prod[29:0];
					state_q <= S_MM2;
				end
				S_MM2: begin
					hk_q    <= prod[35:0];
					state_q <= S_MM3;
				end
				S_MM3: begin
					acc_q   <= sum[48] ? LEN_MAX : sum[47:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!res_valid_q || result.ready) begin
						res_valid_q <= 1'b1;
						res_len_q   <= acc_q;
						res_cnt_q   <= cnt_q;
						res_sat_q   <= (acc_q == LEN_MAX);
						prev_lat_q  <= new_lat_q;
						prev_lon_q  <= new_lon_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/rgcl_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiply with a registered product, one result per cycle.
// ----------------------------------------------------------------------------
module rgcl_mul (
	input  logic          clk,
	input  rgcl_pkg::mop_t a,
	input  rgcl_pkg::mop_t b,
	output rgcl_pkg::prod_t p
);
	import rgcl_pkg::*;

	prod_t p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

// ===== hdl/rgcl_isqrt.sv =====
// ----------------------------------------------------------------------------
// Iterative square root
// Floor square root of a 61-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module rgcl_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [60:0] n,
	output logic [30:0] r,
	output logic        done
);
	import rgcl_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [60:0] n_q;
	logic [60:0] r_q;
	logic [60:0] b_q;
	logic [61:0] trial;

	assign trial = {1'b0, r_q} + {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && b_q == 61'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= n;
			r_q <= '0;
			b_q <= 61'd1 << 60;
		end else if (busy_q) begin
			if ({1'b0, n_q} >= trial) begin
				n_q <= n_q - trial[60:0];
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

	assign r    = r_q[30:0];
	assign done = done_q;

endmodule

// ===== hdl/rgcl_cordic.sv =====
// ----------------------------------------------------------------------------
// Shared CORDIC unit
// Rotation or vectoring mode, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module rgcl_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  rgcl_pkg::cord_ctl_t ctl,
	input  rgcl_pkg::dat_t      x0,
	input  rgcl_pkg::dat_t      y0,
	input  rgcl_pkg::dat_t      z0,
	output rgcl_pkg::dat_t      x,
	output rgcl_pkg::dat_t      y,
	output rgcl_pkg::dat_t      z,
	output logic                done
);
	import rgcl_pkg::*;

	logic          busy_q;
	logic          done_q;
	logic          vec_q;
	logic [IW-1:0] it_q;
	dat_t          x_q;
	dat_t          y_q;
	dat_t          z_q;
	dat_t          dx;
	dat_t          dy;
	logic          sub;

	assign dx  = y_q >>> it_q;
	assign dy  = x_q >>> it_q;
	assign sub = vec_q ? (y_q > 0) : (z_q < 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			vec_q  <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				vec_q  <= ctl.vector;
				it_q   <= '0;
			end else if (busy_q) begin
				if (it_q == IW'(CORDIC_ITERATIONS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					it_q <= it_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
		end else if (busy_q) begin
			if (sub) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ATAN_TAB[it_q];
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ATAN_TAB[it_q];
			end
		end
	end

	assign x    = x_q;
	assign y    = y_q;
	assign z    = z_q;
	assign done = done_q;

endmodule

// ===== hdl/rgcl_checker.sv =====
// ----------------------------------------------------------------------------
// Route great-circle length checker
// Port-level temporal checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "route_great_circle_length_assert.svh"

module rgcl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        stop_valid,
	input logic        stop_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [47:0] route_length_mm,
	input logic [15:0] stop_total,
	input logic        length_saturated
);
	import rgcl_pkg::*;

	`RGCL_ASSERT_NEXT(a_busy_after_transfer, stop_valid && stop_ready, !stop_ready)
	`RGCL_ASSERT_NEXT(a_no_result_next, stop_valid && stop_ready, !$rose(result_valid))
	`RGCL_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(route_length_mm) && $stable(stop_total))
	`RGCL_ASSERT_SAME(a_sat_flag, result_valid && length_saturated, route_length_mm == LEN_MAX)

endmodule

bind route_great_circle_length rgcl_checker u_rgcl_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.stop_valid       (stop.valid),
	.stop_ready       (stop.ready),
	.result_valid     (result.valid),
	.result_ready     (result.ready),
	.route_length_mm  (result.route_length_mm),
	.stop_total       (result.stop_total),
	.length_saturated (result.length_saturated)
);
